/* rtl/core/sat_pkg.sv */
`default_nettype none

package sat_pkg;

    localparam int DEFAULT_MAX_ROWS  = 64;
    localparam int DEFAULT_MAX_COLS  = 64;
    localparam int DEFAULT_SUM_WIDTH = 32;

    localparam int DIM_W       = 7;
    localparam int COORD_W     = 6;
    localparam int ELEM_W      = 32;
    localparam int SUM_OUT_W   = 32;
    localparam int STATUS_W    = 2;
    localparam int CFG_INDEX_W = 1;

    localparam logic [DIM_W-1:0] DIM_RESET = 7'd64;

    localparam logic [CFG_INDEX_W-1:0] REG_NUM_ROWS = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_NUM_COLS = 1'b1;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam logic [STATUS_W-1:0] STAT_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_BAD_RECT   = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_INCOMPLETE = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_OVERFLOW   = 2'd3;

    // Query terms in read order: D - LL - UR + A
    localparam logic [1:0] TERM_D  = 2'd0;
    localparam logic [1:0] TERM_LL = 2'd1;
    localparam logic [1:0] TERM_UR = 2'd2;
    localparam logic [1:0] TERM_A  = 2'd3;

    typedef struct packed {
        logic                      cmd;
        logic                      restart;
        logic signed [ELEM_W-1:0]  element;
        logic [COORD_W-1:0]        top_row;
        logic [COORD_W-1:0]        left_col;
        logic [COORD_W-1:0]        bottom_row;
        logic [COORD_W-1:0]        right_col;
    } sat_in_t;

    typedef struct packed {
        logic signed [SUM_OUT_W-1:0] sum;
        logic [STATUS_W-1:0]         status;
    } sat_out_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_LOAD_WR,
        S_QUERY,
        S_QUERY_LAST
    } sat_state_t;

    typedef struct packed {
        logic                accept;
        logic                run_load;
        logic                load_write;
        logic                qry_read;
        logic [1:0]          qry_term;
        logic                qry_acc;
        logic                acc_clear;
        logic                set_result;
        logic [STATUS_W-1:0] result_status;
    } sat_cmd_t;

    typedef struct packed {
        logic is_query;
        logic load_overflow;
        logic table_incomplete;
        logic bad_rect;
        logic out_free;
    } sat_stat_t;

endpackage

`default_nettype wire

/* rtl/core/sat_ram.sv */
`default_nettype none

module sat_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* rtl/core/sat_ctrl.sv */
`default_nettype none

module sat_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             item_valid,
    output logic                  item_ready,
    input  wire sat_pkg::sat_stat_t stat,
    output sat_pkg::sat_cmd_t     cmd
);

    import sat_pkg::*;

    sat_state_t state_reg, state_next;
    logic [1:0] term_reg, term_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            term_reg  <= TERM_D;
        end
        else
        begin
            state_reg <= state_next;
            term_reg  <= term_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        term_next  = term_reg;
        item_ready = 1'b0;
        cmd        = '0;
        cmd.result_status = STAT_OK;
        cmd.qry_term      = term_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_DECIDE;
                end
            end

            S_DECIDE:
            begin
                if (stat.is_query)
                begin
                    if (stat.table_incomplete || stat.bad_rect)
                    begin
                        cmd.result_status = stat.table_incomplete ? STAT_INCOMPLETE
                                                                  : STAT_BAD_RECT;
                        if (stat.out_free)
                        begin
                            cmd.set_result = 1'b1;
                            state_next     = S_IDLE;
                        end
                    end
                    else
                    begin
                        cmd.qry_read  = 1'b1;
                        cmd.qry_term  = TERM_D;
                        cmd.acc_clear = 1'b1;
                        term_next     = TERM_LL;
                        state_next    = S_QUERY;
                    end
                end
                else if (stat.load_overflow)
                begin
                    cmd.result_status = STAT_OVERFLOW;
                    if (stat.out_free)
                    begin
                        cmd.set_result = 1'b1;
                        state_next     = S_IDLE;
                    end
                end
                else
                begin
                    cmd.run_load = 1'b1;
                    state_next   = S_LOAD_WR;
                end
            end

            S_LOAD_WR:
            begin
                if (stat.out_free)
                begin
                    cmd.load_write = 1'b1;
                    cmd.set_result = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            S_QUERY:
            begin
                // read this term, fold in the one read last cycle
                cmd.qry_read = 1'b1;
                cmd.qry_acc  = 1'b1;
                unique case (term_reg)
                    TERM_LL: term_next = TERM_UR;
                    TERM_UR: term_next = TERM_A;
                    TERM_A:  state_next = S_QUERY_LAST;
                    default: term_next = TERM_LL;
                endcase
            end

            S_QUERY_LAST:
            begin
                if (stat.out_free)
                begin
                    cmd.qry_acc    = 1'b1;
                    cmd.set_result = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    a_accept_to_decide: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept |=> state_reg == S_DECIDE)
        else $error("accepted item did not move to decode");

    a_result_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.set_result |-> stat.out_free)
        else $error("result written over an untaken beat");

    a_query_runs_four_reads: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_QUERY && term_reg == TERM_A) |=> state_reg == S_QUERY_LAST)
        else $error("query read sequence broken");

endmodule

`default_nettype wire

/* rtl/core/sat_datapath.sv */
`default_nettype none

module sat_datapath #(
    parameter int MAX_ROWS  = sat_pkg::DEFAULT_MAX_ROWS,
    parameter int MAX_COLS  = sat_pkg::DEFAULT_MAX_COLS,
    parameter int SUM_WIDTH = sat_pkg::DEFAULT_SUM_WIDTH
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire sat_pkg::sat_in_t                    item,
    input  wire logic                                cfg_we,
    input  wire logic [sat_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  wire logic [sat_pkg::DIM_W-1:0]           cfg_wdata,
    output logic                                     result_valid,
    input  wire logic                                result_ready,
    output sat_pkg::sat_out_t                        result,
    input  wire sat_pkg::sat_cmd_t                   cmd,
    output sat_pkg::sat_stat_t                       stat
);

    import sat_pkg::*;

    localparam int ROW_W  = $clog2(MAX_ROWS + 1);
    localparam int COL_W  = $clog2(MAX_COLS + 1);
    localparam int COL_IW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int DEPTH  = MAX_ROWS * MAX_COLS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    function automatic logic [ADDR_W-1:0] addr_of(input int unsigned r, input int unsigned c);
        return ADDR_W'(r * MAX_COLS + c);
    endfunction

    logic [DIM_W-1:0]     num_rows_reg, num_cols_reg;
    logic [ROW_W-1:0]     load_row_reg, load_row_next;
    logic [COL_IW-1:0]    load_col_reg, load_col_next;
    logic [SUM_WIDTH-1:0] running_reg, running_next;
    logic [SUM_WIDTH-1:0] acc_reg;
    logic                 rd_use_reg, rd_sub_reg;
    sat_in_t              item_reg;
    sat_out_t             result_reg, result_next;
    logic                 result_valid_reg;

    logic [ROW_W-1:0]     rows;
    logic [COL_W-1:0]     cols;
    logic [SUM_WIDTH-1:0] rdata, term_val, entry, acc_next, res_sum;
    logic                 mem_we, mem_re;
    logic [ADDR_W-1:0]    waddr, raddr;
    logic [COORD_W-1:0]   q_row, q_col;
    logic                 q_use;
    logic                 restart_now, col_wrap;

    // Out-of-range dimensions: zero acts as one, too large acts as the maximum
    always_comb
    begin
        if (num_rows_reg == '0)
            rows = ROW_W'(1);
        else if (32'(num_rows_reg) > 32'(MAX_ROWS))
            rows = ROW_W'(MAX_ROWS);
        else
            rows = ROW_W'(num_rows_reg);

        if (num_cols_reg == '0)
            cols = COL_W'(1);
        else if (32'(num_cols_reg) > 32'(MAX_COLS))
            cols = COL_W'(MAX_COLS);
        else
            cols = COL_W'(num_cols_reg);
    end

    always_comb
    begin
        stat.is_query         = (item_reg.cmd == CMD_QUERY);
        stat.load_overflow    = (load_row_reg >= rows) || (COL_W'(load_col_reg) >= cols);
        stat.table_incomplete = (load_row_reg < rows);
        stat.bad_rect         = (item_reg.top_row > item_reg.bottom_row)
                             || (item_reg.left_col > item_reg.right_col)
                             || (32'(item_reg.bottom_row) >= 32'(rows))
                             || (32'(item_reg.right_col) >= 32'(cols));
        stat.out_free         = !result_valid_reg || result_ready;
    end

    // Corner of the current query term; a term on row or column -1 is zero
    always_comb
    begin
        q_row = item_reg.bottom_row;
        q_col = item_reg.right_col;
        q_use = 1'b1;
        unique case (cmd.qry_term)
            TERM_D:
            begin
                q_row = item_reg.bottom_row;
                q_col = item_reg.right_col;
                q_use = 1'b1;
            end
            TERM_LL:
            begin
                q_row = item_reg.bottom_row;
                q_col = item_reg.left_col - COORD_W'(1);
                q_use = (item_reg.left_col != '0);
            end
            TERM_UR:
            begin
                q_row = item_reg.top_row - COORD_W'(1);
                q_col = item_reg.right_col;
                q_use = (item_reg.top_row != '0);
            end
            TERM_A:
            begin
                q_row = item_reg.top_row - COORD_W'(1);
                q_col = item_reg.left_col - COORD_W'(1);
                q_use = (item_reg.top_row != '0) && (item_reg.left_col != '0);
            end
            default:
            begin
                q_use = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        waddr  = addr_of(32'(load_row_reg), 32'(load_col_reg));
        mem_we = cmd.load_write;
        mem_re = 1'b0;
        raddr  = addr_of(32'(q_row), 32'(q_col));
        if (cmd.run_load)
        begin
            raddr  = addr_of(32'(load_row_reg - ROW_W'(1)), 32'(load_col_reg));
            mem_re = (load_row_reg != '0);
        end
        else if (cmd.qry_read)
        begin
            mem_re = q_use;
        end
    end

    sat_ram #(
        .WIDTH (SUM_WIDTH),
        .DEPTH (DEPTH),
        .ADDR_W(ADDR_W)
    ) u_table (
        .clk  (clk),
        .we   (mem_we),
        .waddr(waddr),
        .wdata(entry),
        .re   (mem_re),
        .raddr(raddr),
        .rdata(rdata)
    );

    assign term_val = rd_use_reg ? rdata : '0;
    assign entry    = running_reg + term_val;
    assign acc_next = rd_sub_reg ? (acc_reg - term_val) : (acc_reg + term_val);
    assign col_wrap = (COL_W'(load_col_reg) + COL_W'(1)) >= cols;
    assign restart_now = cmd.accept && (item.cmd == CMD_LOAD) && item.restart;

    always_comb
    begin
        load_row_next = load_row_reg;
        load_col_next = load_col_reg;
        running_next  = running_reg;
        if (cfg_we || restart_now)
        begin
            load_row_next = '0;
            load_col_next = '0;
            running_next  = '0;
        end
        else if (cmd.run_load)
        begin
            running_next = running_reg + SUM_WIDTH'(item_reg.element);
        end
        else if (cmd.load_write)
        begin
            if (col_wrap)
            begin
                load_col_next = '0;
                load_row_next = load_row_reg + ROW_W'(1);
                running_next  = '0;
            end
            else
            begin
                load_col_next = load_col_reg + COL_IW'(1);
            end
        end
    end

    always_comb
    begin
        if (cmd.load_write)
            res_sum = entry;
        else if (cmd.qry_acc)
            res_sum = acc_next;
        else
            res_sum = '0;
        result_next.sum    = SUM_OUT_W'(res_sum);
        result_next.status = cmd.result_status;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_rows_reg     <= DIM_RESET;
            num_cols_reg     <= DIM_RESET;
            load_row_reg     <= '0;
            load_col_reg     <= '0;
            running_reg      <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_NUM_ROWS: num_rows_reg <= cfg_wdata;
                    REG_NUM_COLS: num_cols_reg <= cfg_wdata;
                    default:      num_rows_reg <= num_rows_reg;
                endcase
            end
            load_row_reg <= load_row_next;
            load_col_reg <= load_col_next;
            running_reg  <= running_next;
            if (cmd.set_result)
                result_valid_reg <= 1'b1;
            else if (result_ready)
                result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
            item_reg <= item;
        if (cmd.acc_clear)
            acc_reg <= '0;
        else if (cmd.qry_acc)
            acc_reg <= acc_next;
        if (cmd.run_load)
        begin
            rd_use_reg <= (load_row_reg != '0);
            rd_sub_reg <= 1'b0;
        end
        else if (cmd.qry_read)
        begin
            rd_use_reg <= q_use;
            rd_sub_reg <= (cmd.qry_term == TERM_LL) || (cmd.qry_term == TERM_UR);
        end
        if (cmd.set_result)
            result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    a_single_port: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_we && mem_re))
        else $error("table read and write in the same cycle");

    a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        COL_W'(load_col_reg) < cols)
        else $error("load column past the columns in use");

    a_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        load_row_reg <= rows)
        else $error("load row past the rows in use");

endmodule

`default_nettype wire

/* rtl/core/summed_area_table_query.sv */
// Channel   Direction  Handshake                   Beat
// item      in         item_valid / item_ready     sat_in_t: load element or query corners
// result    out        result_valid / result_ready sat_out_t: sum and status
// config    in         cfg_we (no wait)            cfg_index selects num_rows or num_cols
//
// A load goes from accept through decide and write states; a query reads its four
// corners in turn through the table's one read port with registered read data.
// Refused items (overflow, bad rectangle, incomplete table) end in the decide state.
// Reset clears the load position, the row sum and the result valid; table contents
// are not cleared and need no clearing pass.
// A new item is taken while a result beat waits; the item stalls only at its last step.
`default_nettype none

module summed_area_table_query #(
    parameter int MAX_ROWS  = sat_pkg::DEFAULT_MAX_ROWS,
    parameter int MAX_COLS  = sat_pkg::DEFAULT_MAX_COLS,
    parameter int SUM_WIDTH = sat_pkg::DEFAULT_SUM_WIDTH
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            item_valid,
    output logic                                 item_ready,
    input  wire sat_pkg::sat_in_t                item,
    output logic                                 result_valid,
    input  wire logic                            result_ready,
    output sat_pkg::sat_out_t                    result,
    input  wire logic                            cfg_we,
    input  wire logic [sat_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [sat_pkg::DIM_W-1:0]       cfg_wdata
);

    import sat_pkg::*;

    sat_cmd_t  cmd;
    sat_stat_t stat;

    sat_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .item_valid(item_valid),
        .item_ready(item_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    sat_datapath #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS),
        .SUM_WIDTH(SUM_WIDTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .item        (item),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .result      (result),
        .cmd         (cmd),
        .stat        (stat)
    );

endmodule

`default_nettype wire
